FILE: rtl/tis_pkg.sv
package tis_pkg;

   // Character codes the scanner reacts to
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // Command queue between scanner and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_EXPR,
      MODE_DQ,
      MODE_SQ
   } scan_mode_type;

   typedef enum logic {
      OP_EMIT,
      OP_PUSH
   } op_kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       seg_kind;
      logic       seg_end;
      logic       done_res;
      logic       unclosed_error;
      logic       has_expression;
      logic       overflow;
   } item_type;

   // One command for the emitter. OP_PUSH parks a blank (item.out_byte holds it);
   // OP_EMIT sends item, after draining parked blanks when flush is set.
   typedef struct packed {
      op_kind_type kind;
      logic        flush;
      logic        clear;
      item_type    item;
   } op_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_ESC,
      F_FIN_HELD,
      F_FIN_END,
      F_FIN_DONE
   } front_state_type;

   typedef enum logic {
      B_RUN,
      B_FLUSH
   } back_state_type;

endpackage

FILE: rtl/tis_front.sv
module tis_front #(
   parameter int MAX_PENDING_WS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   input  logic              req_in_empty,
   output logic              q_push,
   output tis_pkg::op_type   q_push_op,
   input  logic              q_full
);

   localparam int CW = $clog2(MAX_PENDING_WS + 1);

   typedef struct packed {
      logic            valid;
      tis_pkg::op_type op;
      logic            started;
      logic [CW-1:0]   count;
   } content_type;

   tis_pkg::front_state_type state_ff, state_in;
   tis_pkg::scan_mode_type   mode_ff, mode_in;
   logic [7:0]    held_byte_ff, held_byte_in;
   logic          held_valid_ff, held_valid_in;
   logic          started_ff, started_in;
   logic [CW-1:0] count_ff, count_in;
   logic          any_expr_ff, any_expr_in;
   logic [7:0]    esc_byte_ff, esc_byte_in;
   logic          last_ff, last_in;
   content_type   res_held;
   content_type   res_esc;

   // Trimming decision for one expression byte
   function automatic content_type content_op(input logic [7:0] c, input logic started,
                                              input logic [CW-1:0] count);
      content_type res;
      logic        blank;
      res = '0;
      res.started = started;
      res.count   = count;
      blank = (c == tis_pkg::CH_SPACE) || (c == tis_pkg::CH_TAB);
      res.op.kind          = tis_pkg::OP_EMIT;
      res.op.item.seg_kind = 1'b1;
      if (blank) begin
         if (started) begin
            res.valid = 1'b1;
            if (count < CW'(MAX_PENDING_WS)) begin
               res.op.kind          = tis_pkg::OP_PUSH;
               res.op.item.out_byte = c;
               res.count            = count + CW'(1);
            end else begin
               res.op.item.overflow = 1'b1;
            end
         end
      end else begin
         res.valid             = 1'b1;
         res.op.flush          = (count != '0);
         res.op.item.out_byte  = c;
         res.op.item.has_byte  = 1'b1;
         res.count             = '0;
         res.started           = 1'b1;
      end
      return res;
   endfunction

   assign res_held = content_op(held_byte_ff, started_ff, count_ff);
   assign res_esc  = content_op(esc_byte_ff, started_ff, count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tis_pkg::F_IDLE;
         mode_ff       <= tis_pkg::MODE_TEXT;
         held_valid_ff <= 1'b0;
         started_ff    <= 1'b0;
         count_ff      <= '0;
         any_expr_ff   <= 1'b0;
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         started_ff    <= started_in;
         count_ff      <= count_in;
         any_expr_ff   <= any_expr_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      esc_byte_ff  <= esc_byte_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      started_in    = started_ff;
      count_in      = count_ff;
      any_expr_in   = any_expr_ff;
      esc_byte_in   = esc_byte_ff;
      last_in       = last_ff;
      q_push        = 1'b0;
      q_push_op     = '0;
      req_stall     = !((state_ff == tis_pkg::F_IDLE) && !q_full);

      unique case (state_ff)
         tis_pkg::F_IDLE: begin
            if (req_valid && !q_full) begin
               last_in = req_in_last;
               if (req_in_empty) begin
                  state_in = tis_pkg::F_FIN_HELD;
               end else if (!held_valid_ff) begin
                  held_byte_in  = req_in_byte;
                  held_valid_in = 1'b1;
                  state_in      = req_in_last ? tis_pkg::F_FIN_HELD : tis_pkg::F_IDLE;
               end else begin
                  held_byte_in = req_in_byte;
                  state_in     = req_in_last ? tis_pkg::F_FIN_HELD : tis_pkg::F_IDLE;
                  unique case (mode_ff)
                     tis_pkg::MODE_TEXT: begin
                        if (held_byte_ff == tis_pkg::CH_LBRACE &&
                            req_in_byte == tis_pkg::CH_LBRACE) begin
                           q_push                  = started_ff;
                           q_push_op.kind          = tis_pkg::OP_EMIT;
                           q_push_op.item.seg_end  = 1'b1;
                           started_in              = 1'b0;
                           mode_in                 = tis_pkg::MODE_EXPR;
                           held_valid_in           = 1'b0;
                        end else begin
                           q_push                  = 1'b1;
                           q_push_op.kind          = tis_pkg::OP_EMIT;
                           q_push_op.item.out_byte = held_byte_ff;
                           q_push_op.item.has_byte = 1'b1;
                           started_in              = 1'b1;
                        end
                     end
                     tis_pkg::MODE_EXPR: begin
                        if (held_byte_ff == tis_pkg::CH_RBRACE &&
                            req_in_byte == tis_pkg::CH_RBRACE) begin
                           count_in                = '0;
                           q_push                  = started_ff;
                           q_push_op.kind          = tis_pkg::OP_EMIT;
                           q_push_op.clear         = 1'b1;
                           q_push_op.item.seg_kind = 1'b1;
                           q_push_op.item.seg_end  = 1'b1;
                           any_expr_in             = any_expr_ff || started_ff;
                           started_in              = 1'b0;
                           mode_in                 = tis_pkg::MODE_TEXT;
                           held_valid_in           = 1'b0;
                        end else begin
                           q_push     = res_held.valid;
                           q_push_op  = res_held.op;
                           started_in = res_held.started;
                           count_in   = res_held.count;
                           if (held_byte_ff == tis_pkg::CH_DQUOTE) begin
                              mode_in = tis_pkg::MODE_DQ;
                           end else if (held_byte_ff == tis_pkg::CH_SQUOTE) begin
                              mode_in = tis_pkg::MODE_SQ;
                           end
                        end
                     end
                     tis_pkg::MODE_DQ, tis_pkg::MODE_SQ: begin
                        q_push     = res_held.valid;
                        q_push_op  = res_held.op;
                        started_in = res_held.started;
                        count_in   = res_held.count;
                        if (held_byte_ff == tis_pkg::CH_BSLASH) begin
                           // escaped pair: second byte is registered and goes out from F_ESC
                           held_valid_in = 1'b0;
                           esc_byte_in   = req_in_byte;
                           state_in      = tis_pkg::F_ESC;
                        end else if ((mode_ff == tis_pkg::MODE_DQ &&
                                      held_byte_ff == tis_pkg::CH_DQUOTE) ||
                                     (mode_ff == tis_pkg::MODE_SQ &&
                                      held_byte_ff == tis_pkg::CH_SQUOTE)) begin
                           mode_in = tis_pkg::MODE_EXPR;
                        end
                     end
                     default: begin
                        mode_in = tis_pkg::MODE_TEXT;
                     end
                  endcase
               end
            end
         end
         tis_pkg::F_ESC: begin
            if (!q_full) begin
               q_push     = res_esc.valid;
               q_push_op  = res_esc.op;
               started_in = res_esc.started;
               count_in   = res_esc.count;
               state_in   = last_ff ? tis_pkg::F_FIN_HELD : tis_pkg::F_IDLE;
            end
         end
         tis_pkg::F_FIN_HELD: begin
            if (!q_full) begin
               if (mode_ff == tis_pkg::MODE_TEXT && held_valid_ff) begin
                  q_push                  = 1'b1;
                  q_push_op.kind          = tis_pkg::OP_EMIT;
                  q_push_op.item.out_byte = held_byte_ff;
                  q_push_op.item.has_byte = 1'b1;
                  started_in              = 1'b1;
               end
               state_in = tis_pkg::F_FIN_END;
            end
         end
         tis_pkg::F_FIN_END: begin
            if (!q_full) begin
               q_push                 = (mode_ff == tis_pkg::MODE_TEXT) && started_ff;
               q_push_op.kind         = tis_pkg::OP_EMIT;
               q_push_op.item.seg_end = 1'b1;
               state_in               = tis_pkg::F_FIN_DONE;
            end
         end
         tis_pkg::F_FIN_DONE: begin
            if (!q_full) begin
               q_push                        = 1'b1;
               q_push_op.kind                = tis_pkg::OP_EMIT;
               q_push_op.clear               = 1'b1;
               q_push_op.item.done_res       = 1'b1;
               q_push_op.item.unclosed_error = (mode_ff != tis_pkg::MODE_TEXT);
               q_push_op.item.has_expression = any_expr_ff;
               mode_in                       = tis_pkg::MODE_TEXT;
               held_valid_in                 = 1'b0;
               started_in                    = 1'b0;
               count_in                      = '0;
               any_expr_in                   = 1'b0;
               state_in                      = tis_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = tis_pkg::F_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/tis_queue.sv
module tis_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tis_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output tis_pkg::op_type head_op,
   output logic            head_valid
);

   localparam int CNT_W = tis_pkg::QPTR_W + 1;
   localparam int PTR_W = tis_pkg::QPTR_W;

   tis_pkg::op_type             slot_ff [tis_pkg::QUEUE_DEPTH];
   logic [tis_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [tis_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full       = (count_ff == CNT_W'(tis_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: rtl/tis_back.sv
module tis_back #(
   parameter int MAX_PENDING_WS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  tis_pkg::op_type   head_op,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tis_pkg::item_type rsp_item
);

   localparam int CW = $clog2(MAX_PENDING_WS + 1);
   localparam int IW = (MAX_PENDING_WS > 1) ? $clog2(MAX_PENDING_WS) : 1;

   logic                     pend_mem [MAX_PENDING_WS];
   logic                     rdata_ff;
   logic [IW-1:0]            rd_addr;
   logic                     wr_en;
   tis_pkg::back_state_type  state_ff, state_in;
   logic [CW-1:0]            wcount_ff, wcount_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            idx_next;
   logic                     valid_ff, valid_in;
   tis_pkg::item_type        item_ff, item_in;
   logic                     load;

   assign load      = !valid_ff || !rsp_stall;
   assign idx_next  = idx_ff + CW'(1);
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   // Blank store: one bit per parked blank, 1 = tab
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pend_mem[wcount_ff[IW-1:0]] <= (head_op.item.out_byte == tis_pkg::CH_TAB);
      end
      rdata_ff <= pend_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tis_pkg::B_RUN;
         wcount_ff <= '0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wcount_ff <= wcount_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_comb begin
      state_in  = state_ff;
      wcount_in = wcount_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && rsp_stall;
      item_in   = item_ff;
      pop       = 1'b0;
      wr_en     = 1'b0;
      rd_addr   = idx_ff[IW-1:0];

      unique case (state_ff)
         tis_pkg::B_RUN: begin
            rd_addr = '0;
            if (head_valid) begin
               unique case (head_op.kind)
                  tis_pkg::OP_PUSH: begin
                     wr_en     = 1'b1;
                     wcount_in = wcount_ff + CW'(1);
                     pop       = 1'b1;
                  end
                  tis_pkg::OP_EMIT: begin
                     if (head_op.flush && wcount_ff != '0) begin
                        state_in = tis_pkg::B_FLUSH;
                        idx_in   = '0;
                     end else if (load) begin
                        valid_in = 1'b1;
                        item_in  = head_op.item;
                        pop      = 1'b1;
                        if (head_op.clear) begin
                           wcount_in = '0;
                        end
                     end
                  end
                  default: begin
                     pop = 1'b0;
                  end
               endcase
            end
         end
         tis_pkg::B_FLUSH: begin
            if (load) begin
               valid_in          = 1'b1;
               item_in           = '0;
               item_in.out_byte  = rdata_ff ? tis_pkg::CH_TAB : tis_pkg::CH_SPACE;
               item_in.has_byte  = 1'b1;
               item_in.seg_kind  = 1'b1;
               if (idx_next == wcount_ff) begin
                  wcount_in = '0;
                  state_in  = tis_pkg::B_RUN;
               end else begin
                  idx_in  = idx_next;
                  rd_addr = idx_next[IW-1:0];
               end
            end
         end
         default: begin
            state_in = tis_pkg::B_RUN;
         end
      endcase
   end

endmodule

FILE: rtl/template_interpolation_splitter.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_in_byte, req_in_last, req_in_empty
// rsp_      out        rsp_valid / rsp_stall  rsp_out_byte .. rsp_overflow (eight fields)
//
// The scanner takes a byte only while idle and the queue has room; a backslash pair inside
// quotes also passes F_ESC, and a string end passes F_FIN_HELD, F_FIN_END and F_FIN_DONE.
// The emitter sends at most one transaction per cycle while rsp_stall is low.
// The four-entry command queue lets the scanner run ahead while the emitter drains.
// Reset is synchronous, active high, and empties queue, output register and blank count.
// rsp_stall holds the output register; the scanner stalls req_ while it finishes an
// escape pair or a string end, and whenever the queue is full.
module template_interpolation_splitter #(
   parameter int MAX_PENDING_WS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       req_in_empty,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_has_byte,
   output logic       rsp_seg_kind,
   output logic       rsp_seg_end,
   output logic       rsp_done_res,
   output logic       rsp_unclosed_error,
   output logic       rsp_has_expression,
   output logic       rsp_overflow
);

   // Scanner to queue
   logic              q_push;
   tis_pkg::op_type   q_push_op;
   logic              q_full;
   // Queue to emitter
   tis_pkg::op_type   q_head_op;
   logic              q_head_valid;
   logic              q_pop;
   tis_pkg::item_type rsp_item;

   // Scanner: tracks brace, quote and escape state, trims leading blanks and
   // turns each transaction into a short series of commands.
   tis_front #(
      .MAX_PENDING_WS(MAX_PENDING_WS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .req_in_empty(req_in_empty),
      .q_push      (q_push),
      .q_push_op   (q_push_op),
      .q_full      (q_full)
   );

   tis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (q_push_op),
      .full      (q_full),
      .pop       (q_pop),
      .head_op   (q_head_op),
      .head_valid(q_head_valid)
   );

   // Emitter: owns the parked-blank store, drains it ahead of the next
   // non-blank expression byte, and drives the output register.
   tis_back #(
      .MAX_PENDING_WS(MAX_PENDING_WS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (q_head_op),
      .head_valid(q_head_valid),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_byte       = rsp_item.out_byte;
   assign rsp_out_has_byte   = rsp_item.has_byte;
   assign rsp_seg_kind       = rsp_item.seg_kind;
   assign rsp_seg_end        = rsp_item.seg_end;
   assign rsp_done_res       = rsp_item.done_res;
   assign rsp_unclosed_error = rsp_item.unclosed_error;
   assign rsp_has_expression = rsp_item.has_expression;
   assign rsp_overflow       = rsp_item.overflow;

endmodule

FILE: rtl/tis_checker.sv
module tis_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_has_byte,
   input logic       rsp_seg_end,
   input logic       rsp_done_res,
   input logic       rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_done_res))
      else $error("rsp payload changed while stalled");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_has_byte |-> rsp_out_byte == 8'h00)
      else $error("byte field set on a transaction without a byte");

   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_out_has_byte && !rsp_seg_end && !rsp_overflow)
      else $error("done transaction carries other marks");

   a_end_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seg_end |-> !rsp_out_has_byte && !rsp_overflow)
      else $error("segment end carries a byte");

endmodule

bind template_interpolation_splitter tis_checker u_tis_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_out_has_byte(rsp_out_has_byte),
   .rsp_seg_end     (rsp_seg_end),
   .rsp_done_res    (rsp_done_res),
   .rsp_overflow    (rsp_overflow)
);

FILE: tb/sv/tb.sv
module tb;

   localparam int BLANK_SLOTS     = 32;    // trailing-blank buffer depth of the DUT
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall for the pressure phase
   localparam int STUCK_LIMIT     = 4000;  // cycles without any transaction before giving up
   localparam int DRAIN_CYCLES    = 60;    // quiet time after the last expected result

   // One request transaction: a template character and its end marks
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty;
   } req_txn_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       req_in_empty = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_has_byte;
   logic       rsp_seg_kind;
   logic       rsp_seg_end;
   logic       rsp_done_res;
   logic       rsp_unclosed_error;
   logic       rsp_has_expression;
   logic       rsp_overflow;

   template_interpolation_splitter #(
      .MAX_PENDING_WS(BLANK_SLOTS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_in_last        (req_in_last),
      .req_in_empty       (req_in_empty),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_has_byte   (rsp_out_has_byte),
      .rsp_seg_kind       (rsp_seg_kind),
      .rsp_seg_end        (rsp_seg_end),
      .rsp_done_res       (rsp_done_res),
      .rsp_unclosed_error (rsp_unclosed_error),
      .rsp_has_expression (rsp_has_expression),
      .rsp_overflow       (rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stimulus and scoreboard storage
   req_txn_type         send_queue[$];       // characters waiting to be offered on req_
   logic [7:0]          tmpl_bytes[$];       // template under construction
   tis_pkg::item_type   expected_items[$];   // result transactions still owed by the DUT

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatches = 0;
   int  stuck_cycles = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;
   bit  hold_off_go = 1'b0;
   bit  hold_off_seen = 1'b0;
   int  hold_left = 0;
   req_txn_type drive_txn;

   int send_pcts[4]  = '{0, 85, 0, 16};
   int stall_pcts[4] = '{0, 0, 85, 16};

   string LETTERS = "abcxyz_019";

   // ---------------------------------------------------------------------------------------
   // Tokenizer prediction: own copy of the scanner state
   // ---------------------------------------------------------------------------------------
   tis_pkg::scan_mode_type tk_mode;
   logic [7:0]    tk_held;
   bit            tk_held_valid;
   bit            tk_seg_open;      // current segment has sent a byte (non-blank in exprs)
   bit            tk_any_expr;
   bit            tk_blank_tab[BLANK_SLOTS];
   int            tk_blank_count;

   function automatic void clear_tokenizer();
      tk_mode        = tis_pkg::MODE_TEXT;
      tk_held        = 8'h00;
      tk_held_valid  = 1'b0;
      tk_seg_open    = 1'b0;
      tk_any_expr    = 1'b0;
      tk_blank_count = 0;
      foreach (tk_blank_tab[k]) tk_blank_tab[k] = 1'b0;
   endfunction

   function automatic void push_result(logic [7:0] b, bit has, bit kind, bit seg_end,
                                       bit done, bit unc, bit hx, bit ovf);
      tis_pkg::item_type it;
      it.out_byte       = b;
      it.has_byte       = has;
      it.seg_kind       = kind;
      it.seg_end        = seg_end;
      it.done_res       = done;
      it.unclosed_error = unc;
      it.has_expression = hx;
      it.overflow       = ovf;
      expected_items.insert(expected_items.size(), it);
   endfunction

   // Expression content: drop leading blanks, park trailing-blank candidates, flag overflow
   function automatic void expr_char(logic [7:0] c);
      if (c == tis_pkg::CH_SPACE || c == tis_pkg::CH_TAB) begin
         if (!tk_seg_open) return;
         if (tk_blank_count < BLANK_SLOTS) begin
            tk_blank_tab[tk_blank_count] = (c == tis_pkg::CH_TAB);
            tk_blank_count++;
         end else begin
            push_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         end
         return;
      end
      // A real character makes the parked blanks interior: release them first
      for (int k = 0; k < tk_blank_count; k++)
         push_result(tk_blank_tab[k] ? tis_pkg::CH_TAB : tis_pkg::CH_SPACE,
                     1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      tk_blank_count = 0;
      tk_seg_open    = 1'b1;
      push_result(c, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
   endfunction

   // Resolve the held byte h now that its successor b is known
   function automatic void scan_pair(logic [7:0] h, logic [7:0] b);
      case (tk_mode)
         tis_pkg::MODE_TEXT: begin
            if (h == tis_pkg::CH_LBRACE && b == tis_pkg::CH_LBRACE) begin
               if (tk_seg_open)
                  push_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
               tk_seg_open   = 1'b0;
               tk_mode       = tis_pkg::MODE_EXPR;
               tk_held_valid = 1'b0;
               return;
            end
            tk_seg_open = 1'b1;
            push_result(h, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
         end
         tis_pkg::MODE_EXPR: begin
            if (h == tis_pkg::CH_RBRACE && b == tis_pkg::CH_RBRACE) begin
               tk_blank_count = 0;   // trailing blanks are trimmed
               if (tk_seg_open) begin
                  push_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                  tk_any_expr = 1'b1;
               end
               tk_seg_open   = 1'b0;
               tk_mode       = tis_pkg::MODE_TEXT;
               tk_held_valid = 1'b0;
               return;
            end
            expr_char(h);
            if (h == tis_pkg::CH_DQUOTE)
               tk_mode = tis_pkg::MODE_DQ;
            else if (h == tis_pkg::CH_SQUOTE)
               tk_mode = tis_pkg::MODE_SQ;
         end
         default: begin
            // Inside quotes a backslash takes its successor as plain content
            if (h == tis_pkg::CH_BSLASH) begin
               expr_char(h);
               expr_char(b);
               tk_held_valid = 1'b0;
               return;
            end
            expr_char(h);
            if ((tk_mode == tis_pkg::MODE_DQ && h == tis_pkg::CH_DQUOTE) ||
                (tk_mode == tis_pkg::MODE_SQ && h == tis_pkg::CH_SQUOTE))
               tk_mode = tis_pkg::MODE_EXPR;
         end
      endcase
      tk_held       = b;
      tk_held_valid = 1'b1;
   endfunction

   // End of string: in text mode flush the held byte and close the text segment; send done
   function automatic void close_string();
      if (tk_mode == tis_pkg::MODE_TEXT) begin
         if (tk_held_valid) begin
            push_result(tk_held, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            tk_seg_open = 1'b1;
         end
         if (tk_seg_open)
            push_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, tk_mode != tis_pkg::MODE_TEXT, tk_any_expr,
                  1'b0);
      clear_tokenizer();
   endfunction

   function automatic void tokenize_byte(logic [7:0] b, bit last, bit empty);
      if (empty) begin
         close_string();
         return;
      end
      if (tk_held_valid) begin
         scan_pair(tk_held, b);
      end else begin
         tk_held       = b;
         tk_held_valid = 1'b1;
      end
      if (last) close_string();
   endfunction

   // ---------------------------------------------------------------------------------------
   // Template generation
   // ---------------------------------------------------------------------------------------
   function automatic void add_byte(logic [7:0] b);
      tmpl_bytes.insert(tmpl_bytes.size(), b);
   endfunction

   function automatic void queue_req(logic [7:0] ch, bit last, bit empty);
      req_txn_type t;
      t.ch    = ch;
      t.last  = last;
      t.empty = empty;
      send_queue.insert(send_queue.size(), t);
   endfunction

   function automatic logic [7:0] rand_letter();
      return LETTERS[$urandom_range(LETTERS.len() - 1)];
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_blanks(int n);
      for (int i = 0; i < n; i++)
         add_byte($urandom_range(1) ? tis_pkg::CH_TAB : tis_pkg::CH_SPACE);
   endfunction

   function automatic void add_word();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) add_byte(rand_letter());
   endfunction

   // Quoted string that may hide closing braces and carry escapes
   function automatic void add_quoted();
      logic [7:0] q;
      int n;
      q = $urandom_range(1) ? tis_pkg::CH_DQUOTE : tis_pkg::CH_SQUOTE;
      n = $urandom_range(0, 4);
      add_byte(q);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: add_byte(rand_letter());
            1: add_byte(tis_pkg::CH_RBRACE);
            2: begin
               add_byte(tis_pkg::CH_BSLASH);
               add_byte($urandom_range(1) ? q : 8'($urandom_range(255)));
            end
            default: add_byte(q == tis_pkg::CH_DQUOTE ? tis_pkg::CH_SQUOTE : tis_pkg::CH_DQUOTE);
         endcase
      end
      add_byte(q);
   endfunction

   function automatic void add_plain_text();
      int n;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(7))
            0: add_byte(8'($urandom_range(255)));
            1: add_byte(tis_pkg::CH_LBRACE);
            default: add_byte(8'($urandom_range(8'h20, 8'h7E)));
         endcase
      end
   endfunction

   function automatic void add_expression(bit long_run, bit closed);
      int pieces;
      add_byte(tis_pkg::CH_LBRACE);
      add_byte(tis_pkg::CH_LBRACE);
      add_blanks($urandom_range(0, 3));
      pieces = $urandom_range(0, 4);
      for (int i = 0; i < pieces; i++) begin
         case ($urandom_range(5))
            0, 1: add_word();
            2: add_blanks($urandom_range(1, 3));
            3: add_quoted();
            4: begin
               add_byte($urandom_range(1) ? tis_pkg::CH_RBRACE : tis_pkg::CH_LBRACE);
               add_byte(rand_letter());
            end
            default: add_byte(8'($urandom_range(255)));
         endcase
      end
      // Blank run longer than the buffer between two words
      if (long_run || $urandom_range(11) == 0) begin
         add_word();
         add_blanks($urandom_range(BLANK_SLOTS + 1, BLANK_SLOTS + 8));
         add_word();
      end
      add_blanks($urandom_range(0, 3));
      if (closed) begin
         add_byte(tis_pkg::CH_RBRACE);
         add_byte(tis_pkg::CH_RBRACE);
      end
   endfunction

   // Template of text and expressions, an unclosed expression ends it
   function automatic void build_template(bit force_overflow);
      int  segs;
      bit  closed;
      segs = $urandom_range(1, 4);
      for (int s = 0; s < segs; s++) begin
         if (!(force_overflow && s == 0) && $urandom_range(1)) begin
            add_plain_text();
         end else begin
            closed = $urandom_range(9) != 0;
            add_expression(force_overflow && s == 0, closed);
            if (!closed) break;
         end
      end
   endfunction

   // Move the template into the send queue, ending with in_last or with an empty mark
   function automatic void flush_template(bit use_empty);
      int n;
      n = tmpl_bytes.size();
      for (int i = 0; i < n; i++)
         queue_req(tmpl_bytes[i], !use_empty && i == n - 1, 1'b0);
      if (use_empty || n == 0)
         queue_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      tmpl_bytes.delete();
   endfunction

   function automatic void gen_phase(int n_items, bit force_overflow);
      int added;
      int start_size;
      int pick;
      added = 0;
      while (added < n_items) begin
         start_size = send_queue.size();
         pick       = $urandom_range(99);
         if (pick < 80) begin
            build_template(force_overflow && added == 0);
         end else if (pick < 94) begin
            // noise built from the characters the scanner reacts to, plus random bytes
            repeat ($urandom_range(1, 12)) begin
               case ($urandom_range(9))
                  0, 1: add_byte(tis_pkg::CH_LBRACE);
                  2, 3: add_byte(tis_pkg::CH_RBRACE);
                  4: add_byte(tis_pkg::CH_DQUOTE);
                  5: add_byte(tis_pkg::CH_SQUOTE);
                  6: add_byte(tis_pkg::CH_BSLASH);
                  7: add_byte(tis_pkg::CH_SPACE);
                  8: add_byte(tis_pkg::CH_TAB);
                  default: add_byte(8'($urandom_range(255)));
               endcase
            end
         end
         flush_template($urandom_range(4) == 0);
         added += send_queue.size() - start_size;
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: change req_ at the falling edge, hold the payload while stalled
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_txn = send_queue.pop_front();
            req_valid    <= 1'b1;
            req_in_byte  <= drive_txn.ch;
            req_in_last  <= drive_txn.last;
            req_in_empty <= drive_txn.empty;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall, or a long hold-off counted here when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_go && !hold_off_seen) begin
         hold_off_seen = 1'b1;
         hold_left     = HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge; predict before checking so a
   // same-cycle result still finds its expectation
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      tis_pkg::item_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_fire = 1'b1;
            tokenize_byte(req_in_byte, req_in_last, req_in_empty);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_fire = 1'b1;
            if (expected_items.size() == 0) begin
               $display("%0t: unexpected transaction: expected none, actual byte %0h has %0b",
                        $time, rsp_out_byte, rsp_out_has_byte);
               $display("%0t:   kind %0b end %0b done %0b unclosed %0b expr %0b ovf %0b",
                        $time, rsp_seg_kind, rsp_seg_end, rsp_done_res, rsp_unclosed_error,
                        rsp_has_expression, rsp_overflow);
               mismatches++;
            end else begin
               want = expected_items.pop_front();
               // out_byte only carries meaning when a byte is present
               if (want.has_byte) compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_bit("out_has_byte", want.has_byte, rsp_out_has_byte);
               compare_bit("seg_kind", want.seg_kind, rsp_seg_kind);
               compare_bit("seg_end", want.seg_end, rsp_seg_end);
               compare_bit("done_res", want.done_res, rsp_done_res);
               compare_bit("unclosed_error", want.unclosed_error, rsp_unclosed_error);
               compare_bit("has_expression", want.has_expression, rsp_has_expression);
               compare_bit("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_fire || rsp_fire)
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
   end

   // Watchdog: end the run once no transaction has moved for too long
   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Sequence: reset, directed strings, random phases, pressure, drain, verdict
   // ---------------------------------------------------------------------------------------
   initial begin
      clear_tokenizer();

      // Directed strings
      // both marks at once: empty wins, byte ignored
      queue_req(8'hFF, 1'b1, 1'b1);
      // byte extremes as text, then an empty mark mid-string ends it
      queue_req(8'h00, 1'b0, 1'b0);
      queue_req(8'hFF, 1'b0, 1'b0);
      queue_req(8'h00, 1'b0, 1'b1);
      // all-blank expression is skipped, then text
      add_text("{{ \t}}x");
      flush_template(1'b0);
      // quoted braces and an escaped quote inside an expression
      add_text("{{\"}}\\\"\"}}");
      flush_template(1'b0);
      // expression left open at the end of the string
      add_text("{{x");
      flush_template(1'b0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (send_queue.size() != 0 || req_valid) @(posedge clock);

      // Random phases with varied idle and stall mixes; the first aims at a blank overflow
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pcts[p];
         recv_stall_pct = stall_pcts[p];
         gen_phase(50, p == 0);
         while (send_queue.size() != 0 || req_valid) @(posedge clock);
      end

      // Pressure: receiver holds off while the sender keeps offering, so the DUT backs up
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_go    = 1'b1;
      gen_phase(40, 1'b0);
      while (send_queue.size() != 0 || req_valid) @(posedge clock);

      // Drain, then give the DUT time to show any stray transaction
      while (expected_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_items.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
